FILE: rtl/core/ifbs_pkg.sv
// Shared types and constants for the information frame byte stuffer.
package ifbs_pkg;

  // Default depth of the request queue between front and back
  localparam int QueueDepthDefault = 4;

  // XOR mask applied to an escaped byte
  localparam logic [7:0] STUFF_MASK = 8'h20;

  // Configuration register indexes
  localparam logic [2:0] REG_FLAG     = 3'd0;
  localparam logic [2:0] REG_ESCAPE   = 3'd1;
  localparam logic [2:0] REG_ADDRESS  = 3'd2;
  localparam logic [2:0] REG_CTL_ZERO = 3'd3;
  localparam logic [2:0] REG_CTL_ONE  = 3'd4;

  // Configuration reset values
  localparam logic [7:0] FLAG_RESET     = 8'h7E;
  localparam logic [7:0] ESCAPE_RESET   = 8'h7D;
  localparam logic [7:0] ADDRESS_RESET  = 8'h03;
  localparam logic [7:0] CTL_ZERO_RESET = 8'h00;
  localparam logic [7:0] CTL_ONE_RESET  = 8'h40;

  // Configuration register set
  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] address;
    logic [7:0] ctl_zero;
    logic [7:0] ctl_one;
  } cfg_t;

  // One classified request, as queued for the back end
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
    logic       seq;
    logic [7:0] bcc;
  } entry_t;

endpackage

FILE: rtl/core/info_frame_byte_stuffer.sv
// Top level of the information frame byte stuffer: config registers, front, queue, back.
// The first line byte of a request passes through the queue and then the output register.
// Throughput: one line byte per cycle while out_stall is low; a request yields 1 to 9 bytes,
// and the queue lets the front take a new request every cycle while it has room.
// Reset (synchronous, active high) empties the queue and output register, clears BCC2 and
// restores all configuration registers to their defaults.
module info_frame_byte_stuffer import ifbs_pkg::*; #(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] payload_byte,
  input  logic       frame_start,
  input  logic       payload_last,
  input  logic       sequence_bit,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] line_byte,
  output logic       run_last,
  output logic       frame_done
);

  cfg_t   cfg;
  logic   queue_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag     <= FLAG_RESET;
      cfg.escape   <= ESCAPE_RESET;
      cfg.address  <= ADDRESS_RESET;
      cfg.ctl_zero <= CTL_ZERO_RESET;
      cfg.ctl_one  <= CTL_ONE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FLAG:     cfg.flag     <= cfg_data;
        REG_ESCAPE:   cfg.escape   <= cfg_data;
        REG_ADDRESS:  cfg.address  <= cfg_data;
        REG_CTL_ZERO: cfg.ctl_zero <= cfg_data;
        REG_CTL_ONE:  cfg.ctl_one  <= cfg_data;
        default: ;
      endcase
    end
  end

  ifbs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .payload_byte (payload_byte),
    .frame_start  (frame_start),
    .payload_last (payload_last),
    .sequence_bit (sequence_bit),
    .queue_full   (queue_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  ifbs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ifbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_byte  (line_byte),
    .run_last   (run_last),
    .frame_done (frame_done)
  );

endmodule

FILE: rtl/core/ifbs_front.sv
// Front end: accepts payload requests, tracks BCC2 and queues classified entries.
module ifbs_front import ifbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] payload_byte,
  input  logic       frame_start,
  input  logic       payload_last,
  input  logic       sequence_bit,
  input  logic       queue_full,
  output logic       push,
  output entry_t     push_entry
);

  logic [7:0] parity;
  logic [7:0] parity_next;

  // Accept whenever the queue has room
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Fold the byte into the running XOR, restarting at frame start
  assign parity_next = (frame_start ? 8'h00 : parity) ^ payload_byte;

  always_comb begin
    push_entry.data  = payload_byte;
    push_entry.start = frame_start;
    push_entry.last  = payload_last;
    push_entry.seq   = sequence_bit;
    push_entry.bcc   = parity_next;
  end

  // Hold the running parity; clear it after the closing request
  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 8'h00;
    end else if (push) begin
      parity <= payload_last ? 8'h00 : parity_next;
    end
  end

endmodule

FILE: rtl/core/ifbs_fifo.sv
// Small request queue between the front end and the back end.
module ifbs_fifo import ifbs_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output entry_t head
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  entry_t         mem [Depth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(Depth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Write the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ifbs_back.sv
// Back end: expands each queued request into stuffed line bytes, one per cycle while the output is not stalled.
module ifbs_back import ifbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] line_byte,
  output logic       run_last,
  output logic       frame_done
);

  typedef enum logic [3:0] {
    PH_FLAG,
    PH_ADDR,
    PH_CTL,
    PH_BCC1,
    PH_DATA,
    PH_DATA_ESC,
    PH_BCC2,
    PH_BCC2_ESC,
    PH_CLOSE
  } phase_t;

  phase_t     phase;
  phase_t     phase_cur;
  phase_t     phase_next;
  logic       fresh;
  logic       load;
  logic       item_done;
  logic       close_byte;
  logic [7:0] byte_next;
  logic [7:0] ctl;
  logic       stuff_data;
  logic       stuff_bcc;

  // Pick the first step for a request not yet started
  assign phase_cur = fresh ? (head.start ? PH_FLAG : PH_DATA) : phase;

  assign ctl        = head.seq ? cfg.ctl_one : cfg.ctl_zero;
  assign stuff_data = (head.data == cfg.escape) || (head.data == cfg.flag);
  assign stuff_bcc  = (head.bcc == cfg.escape) || (head.bcc == cfg.flag);

  // Load the output register when it is empty or being drained
  assign load = head_valid && (!out_valid || !out_stall);
  assign pop  = load && item_done;

  // Decode the current step into a byte and the next step
  always_comb begin
    byte_next  = cfg.flag;
    item_done  = 1'b0;
    close_byte = 1'b0;
    phase_next = PH_FLAG;
    unique case (phase_cur)
      PH_FLAG: begin
        byte_next  = cfg.flag;
        phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        byte_next  = cfg.address;
        phase_next = PH_CTL;
      end
      PH_CTL: begin
        byte_next  = ctl;
        phase_next = PH_BCC1;
      end
      PH_BCC1: begin
        byte_next  = cfg.address ^ ctl;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        if (stuff_data) begin
          byte_next  = cfg.escape;
          phase_next = PH_DATA_ESC;
        end else begin
          byte_next  = head.data;
          phase_next = PH_BCC2;
          item_done  = !head.last;
        end
      end
      PH_DATA_ESC: begin
        byte_next  = head.data ^ STUFF_MASK;
        phase_next = PH_BCC2;
        item_done  = !head.last;
      end
      PH_BCC2: begin
        if (stuff_bcc) begin
          byte_next  = cfg.escape;
          phase_next = PH_BCC2_ESC;
        end else begin
          byte_next  = head.bcc;
          phase_next = PH_CLOSE;
        end
      end
      PH_BCC2_ESC: begin
        byte_next  = head.bcc ^ STUFF_MASK;
        phase_next = PH_CLOSE;
      end
      PH_CLOSE: begin
        byte_next  = cfg.flag;
        close_byte = 1'b1;
        item_done  = 1'b1;
      end
      default: begin
        item_done = 1'b1;
      end
    endcase
  end

  // Hold step state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      fresh     <= 1'b1;
      phase     <= PH_FLAG;
    end else if (load) begin
      out_valid  <= 1'b1;
      line_byte  <= byte_next;
      run_last   <= item_done;
      frame_done <= close_byte;
      fresh      <= item_done;
      phase      <= phase_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/ifbs_checker.sv
// Port-level checks for the information frame byte stuffer, bound to the top level.
module ifbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] line_byte,
  input logic       run_last,
  input logic       frame_done
);

  // Hold a stalled output request
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_byte) && $stable(run_last)
      && $stable(frame_done))
    else $error("stalled output request changed");

  // Closing flag always ends the byte run of its request
  a_close_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> run_last)
    else $error("closing flag not marked as last byte of its request");

  // Drop output after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // Drive a known stall whenever an input request is offered
  a_in_stall_known: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !$isunknown(in_stall))
    else $error("input stall unknown while a request is offered");

endmodule

bind info_frame_byte_stuffer ifbs_checker u_ifbs_checker (.*);
